// File: src/i2crts_pkg.sv
// Shared types and codes for the I2C register transaction sequencer.
`default_nettype none

package i2crts_pkg;

   // Longest transfer a begin word may request
   localparam int unsigned MAX_LENGTH = 256;

   // Function codes of a request word
   localparam logic [1:0] FUNC_BEGIN_WRITE = 2'd0;
   localparam logic [1:0] FUNC_BEGIN_READ  = 2'd1;
   localparam logic [1:0] FUNC_HOST_BYTE   = 2'd2;
   localparam logic [1:0] FUNC_COMPLETION  = 2'd3;

   // Bus engine operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_RSTART = 3'd2;
   localparam logic [2:0] OP_SEND   = 3'd3;
   localparam logic [2:0] OP_RXACK  = 3'd4;
   localparam logic [2:0] OP_RXNACK = 3'd5;
   localparam logic [2:0] OP_STOP   = 3'd6;
   localparam logic [2:0] OP_REQ    = 3'd7;

   // Expected engine status codes (low three bits masked)
   localparam logic [7:0] ST_START   = 8'h08;
   localparam logic [7:0] ST_RSTART  = 8'h10;
   localparam logic [7:0] ST_SLAW_OK = 8'h18;
   localparam logic [7:0] ST_DATA_OK = 8'h28;
   localparam logic [7:0] ST_SLAR_OK = 8'h40;
   localparam logic [7:0] ST_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_RX_NACK = 8'h58;
   localparam logic [7:0] ST_MASK    = 8'hF8;

   // Error codes
   localparam logic [3:0] ERR_OK         = 4'd0;
   localparam logic [3:0] ERR_NOT_ENABLE = 4'd1;
   localparam logic [3:0] ERR_BAD_LENGTH = 4'd2;
   localparam logic [3:0] ERR_START      = 4'd3;
   localparam logic [3:0] ERR_SLAW_NACK  = 4'd4;
   localparam logic [3:0] ERR_REG_NACK   = 4'd5;
   localparam logic [3:0] ERR_DATA_NACK  = 4'd6;
   localparam logic [3:0] ERR_RSTART     = 4'd7;
   localparam logic [3:0] ERR_SLAR_NACK  = 4'd8;
   localparam logic [3:0] ERR_READ       = 4'd9;
   localparam logic [3:0] ERR_UNEXPECTED = 4'd10;

   // Register map (word index)
   localparam logic REG_ENABLE = 1'b0;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [8:0] transfer_length;
      logic [7:0] write_byte;
      logic [7:0] bus_status;
      logic [7:0] rx_data;
   } req_word_type;

   typedef struct packed {
      logic [2:0] bus_op;
      logic [7:0] tx_byte;
      logic [7:0] rx_byte_out;
      logic       rx_valid;
      logic       done_res;
      logic [3:0] error_code;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: src/i2crts_in_stage.sv
// Input register stage: holds one request word until the sequencer takes it.
`default_nettype none

module i2crts_in_stage (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  i2crts_pkg::req_word_type  req_data,
   input  wire                       take,
   output logic                      word_valid,
   output i2crts_pkg::req_word_type  word
);
   import i2crts_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff;
   logic         accept;

   // Full and not drained this cycle: hold off the sender
   assign req_stall = valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         word_ff <= req_data;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

// File: src/i2crts_engine.sv
// State machine: decodes one word per cycle when fired into one result word.
`default_nettype none

module i2crts_engine (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       fire,
   input  i2crts_pkg::req_word_type  word,
   input  wire                       enable,
   output i2crts_pkg::rsp_word_type  result
);
   import i2crts_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_SLAW,
      PH_REG,
      PH_WAIT_HOST,
      PH_DATA,
      PH_RSTART,
      PH_SLAR,
      PH_RBYTE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in;
   logic [8:0] remain_ff, remain_in;
   logic       is_read_ff, is_read_in;

   logic [7:0] status;
   logic [8:0] remain_dec;
   logic       last;
   logic       bad_length;

   assign status     = word.bus_status & ST_MASK;
   assign remain_dec = remain_ff - 9'd1;
   assign last       = (remain_ff == 9'd1);
   assign bad_length = (word.transfer_length == 9'd0)
                       || (32'(word.transfer_length) > MAX_LENGTH);

   // Next state and result for the word in the input register
   always_comb begin
      phase_in   = phase_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      remain_in  = remain_ff;
      is_read_in = is_read_ff;
      result     = '0;

      if (phase_ff == PH_IDLE) begin
         phase_in = PH_IDLE;
         result.done_res = 1'b1;
         if (word.func == FUNC_HOST_BYTE || word.func == FUNC_COMPLETION) begin
            result.error_code = ERR_UNEXPECTED;
         end else if (bad_length) begin
            result.error_code = ERR_BAD_LENGTH;
         end else if (!enable) begin
            result.error_code = ERR_NOT_ENABLE;
         end else begin
            dev_in          = word.device_address;
            reg_in          = word.register_address;
            remain_in       = word.transfer_length;
            is_read_in      = word.func[0];
            phase_in        = PH_START;
            result.done_res = 1'b0;
            result.bus_op   = OP_START;
         end
      end else if (phase_ff == PH_WAIT_HOST) begin
         if (word.func != FUNC_HOST_BYTE) begin
            phase_in          = PH_IDLE;
            result.bus_op     = OP_STOP;
            result.done_res   = 1'b1;
            result.error_code = ERR_UNEXPECTED;
         end else begin
            phase_in       = PH_DATA;
            result.bus_op  = OP_SEND;
            result.tx_byte = word.write_byte;
         end
      end else if (word.func != FUNC_COMPLETION) begin
         phase_in          = PH_IDLE;
         result.bus_op     = OP_STOP;
         result.done_res   = 1'b1;
         result.error_code = ERR_UNEXPECTED;
      end else begin
         // Engine completion: any mismatch ends with stop
         result.bus_op = OP_STOP;
         unique case (phase_ff)
            PH_START: begin
               if (status != ST_START) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_START;
               end else begin
                  phase_in = PH_SLAW;
                  result.bus_op = OP_SEND;
                  result.tx_byte = {dev_ff, 1'b0};
               end
            end
            PH_SLAW: begin
               if (status != ST_SLAW_OK) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_SLAW_NACK;
               end else begin
                  phase_in = PH_REG;
                  result.bus_op = OP_SEND;
                  result.tx_byte = reg_ff;
               end
            end
            PH_REG: begin
               if (status != ST_DATA_OK) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_REG_NACK;
               end else if (is_read_ff) begin
                  phase_in = PH_RSTART;
                  result.bus_op = OP_RSTART;
               end else begin
                  phase_in = PH_WAIT_HOST;
                  result.bus_op = OP_REQ;
               end
            end
            PH_DATA: begin
               if (status != ST_DATA_OK) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_DATA_NACK;
               end else begin
                  remain_in = remain_dec;
                  if (remain_dec == 9'd0) begin
                     phase_in = PH_IDLE;
                     result.done_res = 1'b1;
                  end else begin
                     phase_in = PH_WAIT_HOST;
                     result.bus_op = OP_REQ;
                  end
               end
            end
            PH_RSTART: begin
               if (status != ST_RSTART) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_RSTART;
               end else begin
                  phase_in = PH_SLAR;
                  result.bus_op = OP_SEND;
                  result.tx_byte = {dev_ff, 1'b1};
               end
            end
            PH_SLAR: begin
               if (status != ST_SLAR_OK) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_SLAR_NACK;
               end else begin
                  phase_in = PH_RBYTE;
                  result.bus_op = last ? OP_RXNACK : OP_RXACK;
               end
            end
            PH_RBYTE: begin
               if (status != (last ? ST_RX_NACK : ST_RX_ACK)) begin
                  phase_in = PH_IDLE;
                  result.done_res = 1'b1;
                  result.error_code = ERR_READ;
               end else begin
                  // Byte received: hand it out, then next read or stop
                  remain_in = remain_dec;
                  result.rx_byte_out = word.rx_data;
                  result.rx_valid = 1'b1;
                  if (remain_dec == 9'd0) begin
                     phase_in = PH_IDLE;
                     result.done_res = 1'b1;
                  end else begin
                     result.bus_op = (remain_dec == 9'd1) ? OP_RXNACK : OP_RXACK;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               result.done_res = 1'b1;
               result.error_code = ERR_UNEXPECTED;
            end
         endcase
      end
   end

   // Transaction state, updated once per consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         dev_ff     <= '0;
         reg_ff     <= '0;
         remain_ff  <= '0;
         is_read_ff <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         remain_ff  <= remain_in;
         is_read_ff <= is_read_in;
      end
   end

   // A finished transaction always returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.done_res |=> phase_ff == PH_IDLE)
      else $error("done result did not return to idle");

   // Busy phases always have bytes left to move
   a_remain_busy: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> remain_ff != 9'd0)
      else $error("busy with zero bytes remaining");

   // A received byte goes out only with a read or the closing stop
   a_rx_op: assert property (@(posedge clock) disable iff (reset)
      fire && result.rx_valid |->
         (result.bus_op == OP_RXACK || result.bus_op == OP_RXNACK
          || result.bus_op == OP_STOP))
      else $error("received byte with wrong bus operation");

   // Leaving idle takes an enabled begin and issues start
   a_start_from_begin: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_IDLE && phase_in != PH_IDLE |->
         result.bus_op == OP_START && enable)
      else $error("left idle without issuing start");

endmodule

`default_nettype wire

// File: src/i2crts_out_stage.sv
// Result register: holds one result word until the receiver takes it.
`default_nettype none

module i2crts_out_stage (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       load,
   input  i2crts_pkg::rsp_word_type  result,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output i2crts_pkg::rsp_word_type  rsp_data
);
   import i2crts_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type data_ff;

   // Free when empty or being drained this cycle
   assign can_load = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: src/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer with its register port.
`default_nettype none

// Master-side sequencer for I2C register reads and writes on a byte-level
// bus engine. Every request word (begin write, begin read, host data byte,
// engine completion) yields exactly one result word carrying the next bus
// operation, a received byte, or the transaction's end and error code. A
// word accepted into the input register is decoded there by the state
// machine, and its result is loaded into the result register when that
// register can take it; the result register then offers it. One word
// per cycle is sustained while the result side does not stall. While a
// result waits to be taken, one more word can wait in the input register;
// beyond that the input stalls. The enable register sits at byte address
// 0 and must be set before begin words are accepted without error.
module i2c_register_transaction_sequencer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  i2crts_pkg::req_word_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output i2crts_pkg::rsp_word_type  rsp_data,
   input  wire                       psel,
   input  wire                       penable,
   input  wire                       pwrite,
   input  wire  [2:0]                paddr,
   input  wire  [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import i2crts_pkg::*;

   logic         word_valid;
   req_word_type word;
   rsp_word_type result;
   logic         can_load;
   logic         fire;
   logic         enable_ff;

   // Register port: enable at word 0
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENABLE) begin
         enable_ff <= pwdata[0];
      end
   end

   // A word moves when held and the result register can take its result
   assign fire = word_valid & can_load;

   i2crts_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (fire),
      .word_valid (word_valid),
      .word       (word)
   );

   i2crts_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (word),
      .enable (enable_ff),
      .result (result)
   );

   i2crts_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the I2C register transaction sequencer.
`timescale 1ns / 1ps

module testbench;
   import i2crts_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [2:0] ENABLE_ADDR = 3'(4 * int'(REG_ENABLE));

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_START, SEQ_SLAW, SEQ_REG, SEQ_WAIT_HOST,
      SEQ_DATA, SEQ_RSTART, SEQ_SLAR, SEQ_RBYTE
   } seq_phase_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_word_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_word_type  rsp_data;
   logic          psel = 1'b0;
   logic          penable = 1'b0;
   logic          pwrite = 1'b0;
   logic [2:0]    paddr = '0;
   logic [31:0]   pwdata = '0;
   logic [31:0]   prdata;
   logic          pready;

   // Predicted sequencer state and register copy
   seq_phase_type seq_phase = SEQ_IDLE;
   logic [6:0]    held_device = '0;
   logic [7:0]    held_register = '0;
   logic [8:0]    bytes_left = '0;
   logic          reading = 1'b0;
   logic          enable_setting = 1'b0;

   rsp_word_type  pending_results[$];
   int            words_sent = 0;
   int            results_checked = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   logic [10:0]   codes_seen = '0;
   bit            steady = 1'b0;

   i2c_register_transaction_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 28);
   end

   // Ends a transaction in the predictor
   function automatic rsp_word_type end_sequence(input logic [2:0] op,
                                                 input logic [3:0] err);
      rsp_word_type r;
      r = '0;
      r.bus_op = op;
      r.done_res = 1'b1;
      r.error_code = err;
      seq_phase = SEQ_IDLE;
      return r;
   endfunction

   // Next result word of the sequencer for one accepted request word
   function automatic rsp_word_type advance_sequence(input req_word_type w);
      rsp_word_type r;
      logic [7:0] st;
      logic final_byte;
      r = '0;
      st = w.bus_status & ST_MASK;
      if (seq_phase == SEQ_IDLE) begin
         if (w.func == FUNC_HOST_BYTE || w.func == FUNC_COMPLETION)
            return end_sequence(OP_NONE, ERR_UNEXPECTED);
         if (w.transfer_length == 0 || w.transfer_length > MAX_LENGTH)
            return end_sequence(OP_NONE, ERR_BAD_LENGTH);
         if (!enable_setting)
            return end_sequence(OP_NONE, ERR_NOT_ENABLE);
         held_device = w.device_address;
         held_register = w.register_address;
         bytes_left = w.transfer_length;
         reading = (w.func == FUNC_BEGIN_READ);
         seq_phase = SEQ_START;
         r.bus_op = OP_START;
         return r;
      end
      if (seq_phase == SEQ_WAIT_HOST) begin
         if (w.func != FUNC_HOST_BYTE)
            return end_sequence(OP_STOP, ERR_UNEXPECTED);
         seq_phase = SEQ_DATA;
         r.bus_op = OP_SEND;
         r.tx_byte = w.write_byte;
         return r;
      end
      if (w.func != FUNC_COMPLETION)
         return end_sequence(OP_STOP, ERR_UNEXPECTED);
      case (seq_phase)
         SEQ_START: begin
            if (st != ST_START) return end_sequence(OP_STOP, ERR_START);
            seq_phase = SEQ_SLAW;
            r.bus_op = OP_SEND;
            r.tx_byte = {held_device, 1'b0};
         end
         SEQ_SLAW: begin
            if (st != ST_SLAW_OK) return end_sequence(OP_STOP, ERR_SLAW_NACK);
            seq_phase = SEQ_REG;
            r.bus_op = OP_SEND;
            r.tx_byte = held_register;
         end
         SEQ_REG: begin
            if (st != ST_DATA_OK) return end_sequence(OP_STOP, ERR_REG_NACK);
            seq_phase = reading ? SEQ_RSTART : SEQ_WAIT_HOST;
            r.bus_op = reading ? OP_RSTART : OP_REQ;
         end
         SEQ_DATA: begin
            if (st != ST_DATA_OK) return end_sequence(OP_STOP, ERR_DATA_NACK);
            bytes_left = bytes_left - 9'd1;
            if (bytes_left == 0) return end_sequence(OP_STOP, ERR_OK);
            seq_phase = SEQ_WAIT_HOST;
            r.bus_op = OP_REQ;
         end
         SEQ_RSTART: begin
            if (st != ST_RSTART) return end_sequence(OP_STOP, ERR_RSTART);
            seq_phase = SEQ_SLAR;
            r.bus_op = OP_SEND;
            r.tx_byte = {held_device, 1'b1};
         end
         SEQ_SLAR: begin
            if (st != ST_SLAR_OK) return end_sequence(OP_STOP, ERR_SLAR_NACK);
            seq_phase = SEQ_RBYTE;
            r.bus_op = (bytes_left == 1) ? OP_RXNACK : OP_RXACK;
         end
         SEQ_RBYTE: begin
            final_byte = (bytes_left == 1);
            if (st != (final_byte ? ST_RX_NACK : ST_RX_ACK))
               return end_sequence(OP_STOP, ERR_READ);
            bytes_left = bytes_left - 9'd1;
            r.rx_byte_out = w.rx_data;
            r.rx_valid = 1'b1;
            if (bytes_left == 0) begin
               // last byte rides along with the stop
               seq_phase = SEQ_IDLE;
               r.bus_op = OP_STOP;
               r.done_res = 1'b1;
            end else begin
               r.bus_op = (bytes_left == 1) ? OP_RXNACK : OP_RXACK;
            end
         end
         default: return end_sequence(OP_STOP, ERR_UNEXPECTED);
      endcase
      return r;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.func = 2'($urandom_range(3));
      w.device_address = 7'($urandom_range(127));
      w.register_address = 8'($urandom_range(255));
      w.transfer_length = 9'($urandom_range(511));
      w.write_byte = 8'($urandom_range(255));
      w.bus_status = 8'($urandom_range(255));
      w.rx_data = 8'($urandom_range(255));
      return w;
   endfunction

   function automatic req_word_type begin_word(input logic [1:0] func,
      input logic [6:0] dev, input logic [7:0] regi, input logic [8:0] len);
      req_word_type w;
      w = random_word();
      w.func = func;
      w.device_address = dev;
      w.register_address = regi;
      w.transfer_length = len;
      return w;
   endfunction

   function automatic req_word_type completion_word(input logic [7:0] st,
                                                    input logic [7:0] rx);
      req_word_type w;
      w = random_word();
      w.func = FUNC_COMPLETION;
      w.bus_status = st;
      w.rx_data = rx;
      return w;
   endfunction

   function automatic req_word_type host_word(input logic [7:0] b);
      req_word_type w;
      w = random_word();
      w.func = FUNC_HOST_BYTE;
      w.write_byte = b;
      return w;
   endfunction

   // Well-formed next word for the predicted phase (begins sometimes with a bad length), sometimes corrupted
   function automatic req_word_type next_sequence_word(input int fault_pct);
      req_word_type w;
      int pick;
      logic [7:0] low;
      w = random_word();
      w.func = FUNC_COMPLETION;
      low = 8'($urandom_range(7));
      case (seq_phase)
         SEQ_IDLE: begin
            w.func = $urandom_range(1) ? FUNC_BEGIN_READ : FUNC_BEGIN_WRITE;
            pick = $urandom_range(99);
            if (pick < 65) w.transfer_length = 9'($urandom_range(4, 1));
            else if (pick < 88) w.transfer_length = 9'($urandom_range(16, 5));
            else if (pick < 94) w.transfer_length = 9'($urandom_range(40, 17));
            else if (pick < 97) w.transfer_length = 9'd0;
            else w.transfer_length = 9'($urandom_range(511, MAX_LENGTH + 1));
         end
         SEQ_START:     w.bus_status = ST_START | low;
         SEQ_SLAW:      w.bus_status = ST_SLAW_OK | low;
         SEQ_REG:       w.bus_status = ST_DATA_OK | low;
         SEQ_DATA:      w.bus_status = ST_DATA_OK | low;
         SEQ_RSTART:    w.bus_status = ST_RSTART | low;
         SEQ_SLAR:      w.bus_status = ST_SLAR_OK | low;
         SEQ_RBYTE:     w.bus_status = ((bytes_left == 1) ? ST_RX_NACK : ST_RX_ACK) | low;
         SEQ_WAIT_HOST: w.func = FUNC_HOST_BYTE;
         default: ;
      endcase
      if ($urandom_range(99) < fault_pct) begin
         if ($urandom_range(1)) w.func = 2'($urandom_range(3));
         else w.bus_status = 8'($urandom_range(255));
      end
      return w;
   endfunction

   // Send one request word and record its predicted result
   task automatic send_word(input req_word_type w);
      rsp_word_type r;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      r = advance_sequence(w);
      pending_results.push_back(r);
      if (r.done_res) codes_seen[r.error_code] = 1'b1;
      words_sent++;
   endtask

   // Hold off the sender until every result word is back
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the enable register, then read it back
   task automatic write_enable(input logic value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ENABLE_ADDR;
      pwdata <= ($urandom & ~32'h1) | 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      enable_setting = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== value) begin
         $error("enable: expected %0d, got %0d", value, prdata[0]);
         mismatches++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatches++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expected word pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("bus_op", 8'(want.bus_op), 8'(rsp_data.bus_op));
            check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
            check_field("rx_byte_out", want.rx_byte_out, rsp_data.rx_byte_out);
            check_field("rx_valid", 8'(want.rx_valid), 8'(rsp_data.rx_valid));
            check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
            check_field("error_code", 8'(want.error_code), 8'(rsp_data.error_code));
            results_checked++;
         end
      end
   end

   // Watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Begins while disabled, bad lengths and stray words while idle
   task automatic test_disabled_requests();
      send_word(begin_word(FUNC_BEGIN_WRITE, 7'h00, 8'h00, 9'd1));
      send_word(begin_word(FUNC_BEGIN_READ, 7'h7F, 8'hFF, 9'd0));
      send_word(begin_word(FUNC_BEGIN_WRITE, 7'h55, 8'hAA, 9'd257));
      send_word(host_word(8'hFF));
      send_word(completion_word(ST_START, 8'hFF));
   endtask

   // Clean write, clean read, and words arriving out of turn
   task automatic test_directed_transfers();
      send_word(begin_word(FUNC_BEGIN_WRITE, 7'h7F, 8'hFF, 9'd2));
      send_word(completion_word(ST_START | 8'h07, 8'h00));
      send_word(completion_word(ST_SLAW_OK, 8'h00));
      send_word(completion_word(ST_DATA_OK, 8'h00));
      send_word(host_word(8'hFF));
      send_word(completion_word(ST_DATA_OK, 8'h00));
      send_word(host_word(8'h00));
      send_word(completion_word(ST_DATA_OK | 8'h07, 8'h00));
      send_word(begin_word(FUNC_BEGIN_READ, 7'h00, 8'h00, 9'd2));
      send_word(completion_word(ST_START, 8'h00));
      send_word(completion_word(ST_SLAW_OK, 8'h00));
      send_word(completion_word(ST_DATA_OK, 8'h00));
      send_word(completion_word(ST_RSTART, 8'h00));
      send_word(completion_word(ST_SLAR_OK, 8'h00));
      send_word(completion_word(ST_RX_ACK, 8'hFF));
      send_word(completion_word(ST_RX_NACK | 8'h07, 8'h00));
      // begin while a transaction runs
      send_word(begin_word(FUNC_BEGIN_READ, 7'h12, 8'h34, 9'd1));
      send_word(begin_word(FUNC_BEGIN_WRITE, 7'h12, 8'h34, 9'd1));
      // host byte while waiting on the engine
      send_word(begin_word(FUNC_BEGIN_WRITE, 7'h21, 8'h43, 9'd1));
      send_word(completion_word(ST_START, 8'h00));
      send_word(host_word(8'h5A));
   endtask

   // Full-length write and read without faults
   task automatic test_longest_transfers();
      for (int i = 0; i < 2; i++) begin
         send_word(begin_word(i ? FUNC_BEGIN_READ : FUNC_BEGIN_WRITE,
                              7'($urandom_range(127)), 8'($urandom_range(255)),
                              9'(MAX_LENGTH)));
         while (seq_phase != SEQ_IDLE) send_word(next_sequence_word(0));
      end
   endtask

   // Mostly well-formed transactions with faults and stray words mixed in
   task automatic test_random_traffic(input int count, input int fault_pct);
      int n;
      n = 0;
      while (n < count || seq_phase != SEQ_IDLE) begin
         if ($urandom_range(99) < 5) send_word(random_word());
         else send_word(next_sequence_word(fault_pct));
         n++;
      end
   endtask

   // Same traffic with no idling on either side
   task automatic test_back_to_back(input int count);
      steady = 1'b1;
      test_random_traffic(count, 6);
      steady = 1'b0;
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_disabled_requests();
      wait_for_idle();
      write_enable(1'b1);
      test_directed_transfers();
      test_longest_transfers();
      test_random_traffic(400, 6);
      wait_for_idle();
      write_enable(1'b0);
      test_random_traffic(100, 6);
      wait_for_idle();
      write_enable(1'b1);
      test_back_to_back(400);
      test_random_traffic(300, 12);
      wait_for_idle();
      repeat (10) @(posedge clock);

      $display("Sent %0d request words and checked %0d result words", words_sent,
               results_checked);
      $display("Error codes ended with (bit n for code n): %b", codes_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
